@@ hw/rtl/drag_trajectory_time_of_flight_defines.svh @@
// assertion macros shared by the time-of-flight rtl
// used by dtof_queue and dtof_back; needs i_clk and i_rst_n in scope
`ifndef DRAG_TRAJECTORY_TIME_OF_FLIGHT_DEFINES_SVH
`define DRAG_TRAJECTORY_TIME_OF_FLIGHT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DTOF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dtof assertion failed");
`define DTOF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dtof assertion failed");
`else
`define DTOF_ASSERT_IMP(lbl, ante, cons)
`define DTOF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/dtof_pkg.sv @@
// types, codes and constants for the drag trajectory time-of-flight block
// no dependencies
`timescale 1ns / 1ps
package dtof_pkg;

    localparam int Q_DEPTH  = 4;
    localparam int SQRT_LAT = 64;
    localparam int DIV_LAT  = 34;
    localparam int NUM_W    = 84;
    localparam int DEN_W    = 67;

    typedef enum logic [2:0] {
        CFG_DRAG_COEFF = 3'd0,
        CFG_TVEL_X     = 3'd1,
        CFG_TVEL_Y     = 3'd2,
        CFG_TVEL_Z     = 3'd3,
        CFG_SMALL_THR  = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } t_axis;

    typedef enum logic [1:0] {
        PATH_QUAD  = 2'd0,
        PATH_LIN   = 2'd1,
        PATH_DEGEN = 2'd2
    } t_path;

    typedef struct packed {
        t_axis              axis;
        logic signed [32:0] d;
        logic signed [31:0] v0;
        logic signed [31:0] vi;
        logic               lin;
        logic               opp;
    } t_job;

    typedef struct packed {
        logic  lin;
        logic  degen;
        logic  opp;
        t_axis axis;
    } t_flags;

    typedef struct packed {
        logic signed [65:0] b;
        logic signed [64:0] den;
        logic signed [32:0] d;
        t_flags             f;
    } t_side;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic is_small(input logic signed [31:0] x, input logic [15:0] thr);
        logic [31:0] m;
        m = x[31] ? 32'(-x) : 32'(x);
        return (x == 32'sd0) || (m < {16'h0, thr});
    endfunction

endpackage

@@ hw/rtl/dtof_front.sv @@
// front end: registers a query, picks the solve axis and classifies the path
// depends on dtof_pkg
`timescale 1ns / 1ps
module dtof_front import dtof_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_start_pos_x,
    input  logic signed [31:0] i_start_pos_y,
    input  logic signed [31:0] i_start_pos_z,
    input  logic signed [31:0] i_start_vel_x,
    input  logic signed [31:0] i_start_vel_y,
    input  logic signed [31:0] i_start_vel_z,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_z,
    input  logic signed [31:0] i_now_vel_x,
    input  logic signed [31:0] i_now_vel_y,
    input  logic signed [31:0] i_now_vel_z,
    input  logic signed [31:0] i_drag_coeff,
    input  logic signed [31:0] i_tvel_x,
    input  logic signed [31:0] i_tvel_y,
    input  logic signed [31:0] i_tvel_z,
    input  logic [15:0]        i_small_threshold,
    input  logic               i_q_full,
    output logic               o_push,
    output t_job               o_job
);

    logic               r_fv;
    t_job               r_job;
    t_job               n_job;
    logic signed [32:0] s_dx, s_dy, s_dz;
    logic [32:0]        s_mx, s_my, s_mz;
    logic signed [31:0] s_now;

    assign s_dx = {i_target_x[31], i_target_x} - {i_start_pos_x[31], i_start_pos_x};
    assign s_dy = {i_target_y[31], i_target_y} - {i_start_pos_y[31], i_start_pos_y};
    assign s_dz = {i_target_z[31], i_target_z} - {i_start_pos_z[31], i_start_pos_z};

    always_comb begin
        // displacement first, then launch velocity, then terminal velocity
        if (s_dx != 33'sd0 || s_dy != 33'sd0 || s_dz != 33'sd0) begin
            s_mx = mag33(s_dx);
            s_my = mag33(s_dy);
            s_mz = mag33(s_dz);
        end else if (i_start_vel_x != 32'sd0 || i_start_vel_y != 32'sd0 ||
                     i_start_vel_z != 32'sd0) begin
            s_mx = mag33({i_start_vel_x[31], i_start_vel_x});
            s_my = mag33({i_start_vel_y[31], i_start_vel_y});
            s_mz = mag33({i_start_vel_z[31], i_start_vel_z});
        end else begin
            s_mx = mag33({i_tvel_x[31], i_tvel_x});
            s_my = mag33({i_tvel_y[31], i_tvel_y});
            s_mz = mag33({i_tvel_z[31], i_tvel_z});
        end

        if (s_mx >= s_my && s_mx >= s_mz) n_job.axis = AX_X;
        else if (s_my >= s_mz)            n_job.axis = AX_Y;
        else                              n_job.axis = AX_Z;

        unique case (n_job.axis)
            AX_X: begin
                n_job.d  = s_dx;
                n_job.v0 = i_start_vel_x;
                n_job.vi = i_tvel_x;
                s_now    = i_now_vel_x;
            end
            AX_Y: begin
                n_job.d  = s_dy;
                n_job.v0 = i_start_vel_y;
                n_job.vi = i_tvel_y;
                s_now    = i_now_vel_y;
            end
            default: begin
                n_job.d  = s_dz;
                n_job.v0 = i_start_vel_z;
                n_job.vi = i_tvel_z;
                s_now    = i_now_vel_z;
            end
        endcase

        n_job.lin = is_small(n_job.vi, i_small_threshold) ||
                    is_small(i_drag_coeff, i_small_threshold);
        n_job.opp = (s_now < 32'sd0 && n_job.vi > 32'sd0) ||
                    (s_now > 32'sd0 && n_job.vi < 32'sd0);
    end

    assign o_stall = r_fv && i_q_full;
    assign o_push  = r_fv && !i_q_full;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (!o_stall) begin
            r_fv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_job <= n_job;
        end
    end

endmodule

@@ hw/rtl/dtof_queue.sv @@
// short fifo of classified jobs between front and back
// depends on dtof_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "drag_trajectory_time_of_flight_defines.svh"
module dtof_queue import dtof_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    localparam int PW = $clog2(Q_DEPTH);

    t_job          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_count;

    assign o_full  = (r_count == (PW+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (i_pop && !i_push) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    `DTOF_ASSERT_IMP(a_no_push_full, i_push, !o_full)
    `DTOF_ASSERT_IMP(a_no_pop_empty, i_pop, !o_empty)
    `DTOF_ASSERT_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

@@ hw/rtl/dtof_sqrt.sv @@
// pipelined floor square root of a 128-bit value, one root bit per stage
// depends on dtof_pkg
`timescale 1ns / 1ps
module dtof_sqrt import dtof_pkg::*; (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [127:0] i_x,
    output logic [63:0]  o_root
);

    logic [127:0] r_x    [1:SQRT_LAT-1];
    logic [65:0]  r_rem  [1:SQRT_LAT-1];
    logic [63:0]  r_root [1:SQRT_LAT-1];
    logic [63:0]  r_root_out;

    logic [127:0] s_x    [SQRT_LAT];
    logic [65:0]  s_rem  [SQRT_LAT];
    logic [63:0]  s_root [SQRT_LAT];
    logic [66:0]  s_t    [SQRT_LAT];
    logic [66:0]  s_tr   [SQRT_LAT];
    logic         s_ge   [SQRT_LAT];

    always_comb begin
        s_x[0]    = i_x;
        s_rem[0]  = '0;
        s_root[0] = '0;
        for (int k = 1; k < SQRT_LAT; k++) begin
            s_x[k]    = r_x[k];
            s_rem[k]  = r_rem[k];
            s_root[k] = r_root[k];
        end
        for (int k = 0; k < SQRT_LAT; k++) begin
            // bring down the next two bits and try root*4+1
            s_t[k]  = {s_rem[k][64:0], s_x[k][127:126]};
            s_tr[k] = {1'b0, s_root[k], 2'b01};
            s_ge[k] = (s_t[k] >= s_tr[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQRT_LAT-1; k++) begin
                r_x[k+1]    <= {s_x[k][125:0], 2'b00};
                r_rem[k+1]  <= s_ge[k] ? 66'(s_t[k] - s_tr[k]) : s_t[k][65:0];
                r_root[k+1] <= {s_root[k][62:0], s_ge[k]};
            end
            r_root_out <= {s_root[SQRT_LAT-1][62:0], s_ge[SQRT_LAT-1]};
        end
    end

    assign o_root = r_root_out;

endmodule

@@ hw/rtl/dtof_div.sv @@
// pipelined signed divider, quotient truncated toward zero and saturated to 32 bits
// depends on dtof_pkg
`timescale 1ns / 1ps
module dtof_div import dtof_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [DEN_W-1:0] i_den,
    output logic signed [31:0]      o_quot,
    output logic                    o_sat
);

    localparam int STEPS = 32;

    logic [NUM_W-1:0] s_an_full;
    logic [DEN_W-1:0] s_ad_full;
    logic [NUM_W-2:0] s_an;
    logic [DEN_W-2:0] s_ad;
    logic             s_ovf;

    logic [DEN_W-2:0] r_rem [STEPS];
    logic [31:0]      r_lo  [STEPS];
    logic [DEN_W-2:0] r_dv  [STEPS];
    logic             r_neg [STEPS+1];
    logic             r_ovf [STEPS+1];
    logic             r_dz  [STEPS+1];
    logic [31:0]      r_q   [1:STEPS];

    logic [31:0]      s_qin [STEPS];
    logic [DEN_W-1:0] s_t   [STEPS];
    logic             s_ge  [STEPS];
    logic [31:0]      s_q;
    logic             s_sat;

    assign s_an_full = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign s_ad_full = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
    assign s_an      = s_an_full[NUM_W-2:0];
    assign s_ad      = s_ad_full[DEN_W-2:0];
    // quotient of 2^32 or more is saturated whatever its low bits
    assign s_ovf     = {{(DEN_W+31-NUM_W+1){1'b0}}, s_an} >= {s_ad, 32'h0};

    always_comb begin
        s_qin[0] = 32'h0;
        for (int k = 1; k < STEPS; k++) begin
            s_qin[k] = r_q[k];
        end
        for (int k = 0; k < STEPS; k++) begin
            s_t[k]   = {r_rem[k], r_lo[k][31]};
            s_ge[k]  = (s_t[k] >= {1'b0, r_dv[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= (DEN_W-1)'(s_an[NUM_W-2:32]);
            r_lo[0]  <= s_an[31:0];
            r_dv[0]  <= s_ad;
            r_neg[0] <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
            r_ovf[0] <= s_ovf;
            r_dz[0]  <= (s_ad == '0);
            for (int k = 0; k < STEPS; k++) begin
                if (k < STEPS-1) begin
                    r_rem[k+1] <= s_ge[k] ? (DEN_W-1)'(s_t[k] - {1'b0, r_dv[k]})
                                          : s_t[k][DEN_W-2:0];
                    r_lo[k+1]  <= {r_lo[k][30:0], 1'b0};
                    r_dv[k+1]  <= r_dv[k];
                end
                r_q[k+1]   <= {s_qin[k][30:0], s_ge[k]};
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
                r_dz[k+1]  <= r_dz[k];
            end
        end
    end

    assign s_q = r_q[STEPS];

    always_comb begin
        if (r_dz[STEPS]) begin
            s_sat = 1'b0;
        end else if (!r_neg[STEPS]) begin
            s_sat = r_ovf[STEPS] || s_q[31];
        end else begin
            s_sat = r_ovf[STEPS] || (s_q > 32'h8000_0000);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sat <= s_sat;
            if (r_dz[STEPS])        o_quot <= 32'sd0;
            else if (!r_neg[STEPS]) o_quot <= s_sat ? 32'h7FFF_FFFF : s_q;
            else                    o_quot <= s_sat ? 32'h8000_0000 : 32'(-s_q);
        end
    end

endmodule

@@ hw/rtl/dtof_back.sv @@
// back end: coefficient products, discriminant, square root, both divisions,
// root choice and the output register; depends on dtof_pkg, dtof_sqrt, dtof_div
`timescale 1ns / 1ps
`include "drag_trajectory_time_of_flight_defines.svh"
module dtof_back import dtof_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic signed [31:0] i_drag_coeff,
    input  logic [15:0]        i_small_threshold,
    input  logic               i_q_empty,
    input  t_job               i_job,
    output logic               o_pop,
    input  logic               i_stall,
    output logic               o_valid,
    output logic signed [31:0] o_flight_time,
    output logic [1:0]         o_solve_axis,
    output logic [1:0]         o_solve_path,
    output logic               o_saturated
);

    localparam int L = 5 + SQRT_LAT + 1 + DIV_LAT + 1;

    logic         s_en;
    logic [L-1:0] r_vld;

    // product stages
    logic signed [64:0] r1_dk;
    logic signed [63:0] r1_a;
    logic signed [31:0] r1_v0;
    logic signed [32:0] r1_d;
    t_flags             r1_f;
    logic signed [65:0] r2_b;
    logic signed [64:0] r2_ahid;
    logic signed [65:0] r2_alod;
    logic signed [64:0] r2_den;
    logic signed [32:0] r2_d;
    t_flags             r2_f;
    logic [63:0]        r3_babs;
    logic signed [96:0] r3_ad;
    logic signed [65:0] r3_b;
    logic signed [64:0] r3_den;
    logic signed [32:0] r3_d;
    t_flags             r3_f;
    logic [63:0]        r4_ll, r4_lh, r4_hh;
    logic signed [96:0] r4_ad;
    logic signed [65:0] r4_b;
    logic signed [64:0] r4_den;
    logic signed [32:0] r4_d;
    t_flags             r4_f;
    logic [127:0]       r5_x;
    t_side              r5_side;

    logic signed [65:0] s_bneg;
    logic [127:0]       s_disc;
    logic               s_degen;

    // alignment with the square root and the dividers
    t_side              r_sd  [SQRT_LAT];
    t_flags             r_fd  [DIV_LAT];
    logic [63:0]        s_root;

    logic signed [66:0]        s_mb, s_n1, s_n2;
    logic signed [NUM_W-1:0]   r6_num1, r6_num2;
    logic signed [DEN_W-1:0]   r6_den1, r6_den2;
    t_flags                    r6_f;
    t_side                     s_sd;

    logic signed [31:0] s_q1, s_q2;
    logic               s_s1, s_s2;
    t_flags             s_fo;
    logic signed [31:0] r_out_t;
    t_axis              r_out_axis;
    t_path              r_out_path;
    logic               r_out_sat;

    assign s_en  = !r_vld[L-1] || !i_stall;
    assign o_pop = s_en && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (s_en) begin
            r_vld <= {r_vld[L-2:0], o_pop};
        end
    end

    assign s_bneg = -r2_b;
    assign s_disc = {r4_hh, r4_ll} + {31'h0, r4_lh, 33'h0} +
                    {{13{r4_ad[96]}}, r4_ad, 18'h0};
    assign s_degen = (r3_babs == 64'h0) ||
                     (r3_babs < {32'h0, i_small_threshold, 16'h0});

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r1_dk     <= i_job.d * i_drag_coeff;
            r1_a      <= i_drag_coeff * i_job.vi;
            r1_v0     <= i_job.v0;
            r1_d      <= i_job.d;
            r1_f.lin  <= i_job.lin;
            r1_f.degen <= 1'b0;
            r1_f.opp  <= i_job.opp;
            r1_f.axis <= i_job.axis;

            r2_b    <= {{18{r1_v0[31]}}, r1_v0, 16'h0} - {r1_dk[64], r1_dk};
            r2_ahid <= $signed(r1_a[63:32]) * r1_d;
            r2_alod <= $signed({1'b0, r1_a[31:0]}) * r1_d;
            r2_den  <= {r1_a, 1'b0};
            r2_d    <= r1_d;
            r2_f    <= r1_f;

            r3_babs <= r2_b[65] ? s_bneg[63:0] : r2_b[63:0];
            r3_ad   <= {r2_ahid, 32'h0} + {{31{r2_alod[65]}}, r2_alod};
            r3_b    <= r2_b;
            r3_den  <= r2_den;
            r3_d    <= r2_d;
            r3_f    <= r2_f;

            r4_ll   <= r3_babs[31:0] * r3_babs[31:0];
            r4_lh   <= r3_babs[31:0] * r3_babs[63:32];
            r4_hh   <= r3_babs[63:32] * r3_babs[63:32];
            r4_ad   <= r3_ad;
            r4_b    <= r3_b;
            r4_den  <= r3_den;
            r4_d    <= r3_d;
            r4_f    <= '{lin: r3_f.lin, degen: s_degen, opp: r3_f.opp, axis: r3_f.axis};

            // a discriminant with the top bit set counts as negative
            r5_x       <= s_disc[127] ? 128'h0 : s_disc;
            r5_side.b   <= r4_b;
            r5_side.den <= r4_den;
            r5_side.d   <= r4_d;
            r5_side.f   <= r4_f;
        end
    end

    dtof_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (s_en),
        .i_x    (r5_x),
        .o_root (s_root)
    );

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_sd[0] <= r5_side;
            for (int k = 1; k < SQRT_LAT; k++) r_sd[k] <= r_sd[k-1];
        end
    end

    assign s_sd = r_sd[SQRT_LAT-1];
    assign s_mb = -{s_sd.b[65], s_sd.b};
    assign s_n1 = s_mb + {3'b000, s_root};
    assign s_n2 = s_mb - {3'b000, s_root};

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r6_num1 <= s_sd.f.lin ? {{19{s_sd.d[32]}}, s_sd.d, 32'h0}
                                  : {s_n1[66], s_n1, 16'h0};
            r6_den1 <= s_sd.f.lin ? {s_sd.b[65], s_sd.b}
                                  : {{2{s_sd.den[64]}}, s_sd.den};
            r6_num2 <= {s_n2[66], s_n2, 16'h0};
            r6_den2 <= {{2{s_sd.den[64]}}, s_sd.den};
            r6_f    <= s_sd.f;
        end
    end

    dtof_div u_div1 (
        .i_clk  (i_clk),
        .i_en   (s_en),
        .i_num  (r6_num1),
        .i_den  (r6_den1),
        .o_quot (s_q1),
        .o_sat  (s_s1)
    );

    dtof_div u_div2 (
        .i_clk  (i_clk),
        .i_en   (s_en),
        .i_num  (r6_num2),
        .i_den  (r6_den2),
        .o_quot (s_q2),
        .o_sat  (s_s2)
    );

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_fd[0] <= r6_f;
            for (int k = 1; k < DIV_LAT; k++) r_fd[k] <= r_fd[k-1];
        end
    end

    assign s_fo = r_fd[DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_out_axis <= s_fo.axis;
            if (s_fo.lin && s_fo.degen) begin
                r_out_path <= PATH_DEGEN;
                r_out_t    <= 32'sd0;
                r_out_sat  <= 1'b0;
            end else if (s_fo.lin) begin
                r_out_path <= PATH_LIN;
                r_out_t    <= s_q1;
                r_out_sat  <= s_s1;
            end else begin
                r_out_path <= PATH_QUAD;
                // a negative root loses; otherwise the apex side decides
                if (s_q1 < 32'sd0 || (s_q2 >= 32'sd0 &&
                        (s_fo.opp ? (s_q1 > s_q2) : (s_q1 < s_q2)))) begin
                    r_out_t   <= s_q2;
                    r_out_sat <= s_s2;
                end else begin
                    r_out_t   <= s_q1;
                    r_out_sat <= s_s1;
                end
            end
        end
    end

    assign o_valid       = r_vld[L-1];
    assign o_flight_time = r_out_t;
    assign o_solve_axis  = r_out_axis;
    assign o_solve_path  = r_out_path;
    assign o_saturated   = r_out_sat;

    `DTOF_ASSERT_IMP(a_pop_nonempty, o_pop, !i_q_empty)
    `DTOF_ASSERT_NEXT(a_stage_shift, s_en && r_vld[0], r_vld[1])
    `DTOF_ASSERT_IMP(a_degen_zero, o_valid && r_out_path == PATH_DEGEN, r_out_t == 0 && !r_out_sat)

endmodule

@@ hw/rtl/drag_trajectory_time_of_flight.sv @@
// Time of flight to a target on a rational drag trajectory, Q16.16 fixed point.
// Input channel: i_valid / o_stall with one query per transfer (start position,
// start velocity, target, current velocity). Output channel: o_valid / i_stall with
// one result per query: flight time, solve axis, solve path, saturation flag.
// Configuration: write i_cfg_data to register i_cfg_idx when i_cfg_we is high
// (0 drag coefficient, 1..3 terminal velocity x/y/z, 4 small threshold); write
// only while no query is in flight.
// Throughput: one query per cycle while nothing stalls. On its way a result passes
// a front register, the job queue, five product and discriminant stages, a 64-stage
// square root, a routing stage, a 34-stage divider pair and the output register.
// When i_stall holds the output, the back pipeline freezes; the four-entry queue
// and the front register keep taking queries until the queue fills, then o_stall
// rises. Synchronous active-low reset empties the pipeline and queue and restores
// the register defaults (threshold 1, all others 0).
`timescale 1ns / 1ps
module drag_trajectory_time_of_flight import dtof_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_start_pos_x,
    input  logic signed [31:0] i_start_pos_y,
    input  logic signed [31:0] i_start_pos_z,
    input  logic signed [31:0] i_start_vel_x,
    input  logic signed [31:0] i_start_vel_y,
    input  logic signed [31:0] i_start_vel_z,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_z,
    input  logic signed [31:0] i_now_vel_x,
    input  logic signed [31:0] i_now_vel_y,
    input  logic signed [31:0] i_now_vel_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_flight_time,
    output logic [1:0]         o_solve_axis,
    output logic [1:0]         o_solve_path,
    output logic               o_saturated
);

    logic signed [31:0] r_drag_coeff;
    logic signed [31:0] r_tvel_x, r_tvel_y, r_tvel_z;
    logic [15:0]        r_small_thr;

    logic s_push, s_pop, s_full, s_empty;
    t_job s_fjob, s_qjob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drag_coeff <= 32'sd0;
            r_tvel_x     <= 32'sd0;
            r_tvel_y     <= 32'sd0;
            r_tvel_z     <= 32'sd0;
            r_small_thr  <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DRAG_COEFF: r_drag_coeff <= i_cfg_data;
                CFG_TVEL_X:     r_tvel_x     <= i_cfg_data;
                CFG_TVEL_Y:     r_tvel_y     <= i_cfg_data;
                CFG_TVEL_Z:     r_tvel_z     <= i_cfg_data;
                CFG_SMALL_THR:  r_small_thr  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    dtof_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_start_pos_x     (i_start_pos_x),
        .i_start_pos_y     (i_start_pos_y),
        .i_start_pos_z     (i_start_pos_z),
        .i_start_vel_x     (i_start_vel_x),
        .i_start_vel_y     (i_start_vel_y),
        .i_start_vel_z     (i_start_vel_z),
        .i_target_x        (i_target_x),
        .i_target_y        (i_target_y),
        .i_target_z        (i_target_z),
        .i_now_vel_x       (i_now_vel_x),
        .i_now_vel_y       (i_now_vel_y),
        .i_now_vel_z       (i_now_vel_z),
        .i_drag_coeff      (r_drag_coeff),
        .i_tvel_x          (r_tvel_x),
        .i_tvel_y          (r_tvel_y),
        .i_tvel_z          (r_tvel_z),
        .i_small_threshold (r_small_thr),
        .i_q_full          (s_full),
        .o_push            (s_push),
        .o_job             (s_fjob)
    );

    dtof_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_job   (s_fjob),
        .i_pop   (s_pop),
        .o_job   (s_qjob),
        .o_full  (s_full),
        .o_empty (s_empty)
    );

    dtof_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_drag_coeff      (r_drag_coeff),
        .i_small_threshold (r_small_thr),
        .i_q_empty         (s_empty),
        .i_job             (s_qjob),
        .o_pop             (s_pop),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_flight_time     (o_flight_time),
        .o_solve_axis      (o_solve_axis),
        .o_solve_path      (o_solve_path),
        .o_saturated       (o_saturated)
    );

endmodule

@@ tb/sv/drag_trajectory_time_of_flight_tb.sv @@
// testbench for the drag trajectory time-of-flight block: directed table, then random queries
// over several register settings, each checked against a table row or an in-bench predictor
// depends on dtof_pkg and drag_trajectory_time_of_flight
`timescale 1ns / 1ps
module drag_trajectory_time_of_flight_tb import dtof_pkg::*; ();

    localparam int IDLE_PCT    = 14;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 130;
    localparam int WDOG_LIMIT  = 5000;
    localparam int N_PHASES    = 7;
    localparam int PHASE_ITEMS = 250;

    typedef struct packed {
        logic [11:0][31:0] f;   // start pos xyz, start vel xyz, target xyz, now vel xyz
    } t_query;

    typedef struct packed {
        logic signed [31:0] t;
        t_axis              ax;
        t_path              path;
        logic               sat;
    } t_tof;

    typedef struct packed {
        t_query q;
        logic   has_exp;
        t_tof   exp;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    t_query             cur_q = '0;
    logic               cur_has_exp = 1'b0;
    t_tof               cur_exp = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_flight_time;
    logic [1:0]         o_solve_axis;
    logic [1:0]         o_solve_path;
    logic               o_saturated;

    // register copies
    logic signed [31:0] k_reg = '0;
    logic signed [31:0] tv_reg [3] = '{default: '0};
    logic [15:0]        thr_reg = 16'd1;

    t_tof tof_q [$];
    int   n_sent = 0, n_done = 0, n_bad = 0, idle_cnt = 0;
    int   n_path [3] = '{default: 0};
    bit   calm = 0, press_req = 0, press_done = 0;
    int   hold_cnt = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    drag_trajectory_time_of_flight i_dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .o_stall,
        .i_start_pos_x(cur_q.f[0]), .i_start_pos_y(cur_q.f[1]), .i_start_pos_z(cur_q.f[2]),
        .i_start_vel_x(cur_q.f[3]), .i_start_vel_y(cur_q.f[4]), .i_start_vel_z(cur_q.f[5]),
        .i_target_x(cur_q.f[6]), .i_target_y(cur_q.f[7]), .i_target_z(cur_q.f[8]),
        .i_now_vel_x(cur_q.f[9]), .i_now_vel_y(cur_q.f[10]), .i_now_vel_z(cur_q.f[11]),
        .o_valid, .i_stall, .o_flight_time, .o_solve_axis, .o_solve_path, .o_saturated
    );

    function automatic logic [32:0] abs33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic bit near_zero(input logic signed [31:0] x);
        return x == 0 || abs33(33'(x)) < {17'h0, thr_reg};
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [127:0] x);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            c = r | (64'd1 << i);
            if (x >= {64'h0, c} * {64'h0, c}) r = c;
        end
        return r;
    endfunction

    // truncating quotient, clamped to 32 bits
    function automatic void div_clamp(input logic signed [129:0] n, input logic signed [129:0] d,
                                      output logic signed [31:0] q, output logic s);
        logic [129:0] an, ad, uq;
        logic         neg;
        neg = n[129] ^ d[129];
        an  = n[129] ? -n : n;
        ad  = d[129] ? -d : d;
        uq  = an / ad;
        s   = 1'b0;
        if (!neg) begin
            if (uq > 130'h7FFFFFFF) begin s = 1'b1; q = 32'sh7FFFFFFF; end
            else q = uq[31:0];
        end else begin
            if (uq > 130'h80000000) begin s = 1'b1; q = 32'sh80000000; end
            else q = -uq[31:0];
        end
    endfunction

    function automatic t_tof predict_tof(input t_query q);
        logic signed [32:0]  dl [3];
        logic signed [31:0]  v0 [3];
        logic [32:0]         m [3];
        logic signed [129:0] d, vs, vt, k, b, a, c, mb, rr, den;
        logic signed [129:0] ex;
        logic [127:0]        disc;
        logic signed [31:0]  r1, r2;
        logic                s1, s2, opp;
        logic signed [31:0]  nv;
        int                  ax;
        t_tof                r;
        for (int i = 0; i < 3; i++) begin
            dl[i] = $signed({q.f[6+i][31], q.f[6+i]}) - $signed({q.f[i][31], q.f[i]});
            v0[i] = q.f[3+i];
        end
        for (int i = 0; i < 3; i++) begin
            if (dl[0] != 0 || dl[1] != 0 || dl[2] != 0) m[i] = abs33(dl[i]);
            else if (v0[0] != 0 || v0[1] != 0 || v0[2] != 0) m[i] = abs33(33'(v0[i]));
            else m[i] = abs33(33'(tv_reg[i]));
        end
        if (m[0] >= m[1] && m[0] >= m[2]) ax = 0;
        else if (m[1] >= m[2]) ax = 1;
        else ax = 2;
        d  = dl[ax];
        vs = v0[ax];
        vt = tv_reg[ax];
        k  = k_reg;
        nv = q.f[9+ax];
        b  = vs * 65536 - d * k;
        r.ax  = t_axis'(ax[1:0]);
        r.sat = 1'b0;
        r.t   = '0;
        if (near_zero(tv_reg[ax]) || near_zero(k_reg)) begin
            if (b == 0 || (b[129] ? -b : b) < $signed({114'h0, thr_reg} << 16)) begin
                r.path = PATH_DEGEN;
            end else begin
                r.path = PATH_LIN;
                div_clamp(d <<< 32, b, r.t, r.sat);
            end
        end else begin
            r.path = PATH_QUAD;
            a  = k * vt;
            c  = -(d * 65536);
            ex = b * b - 4 * a * c;
            disc = ex[127:0];
            if (disc[127]) disc = '0;     // negative discriminant clamps to zero
            rr  = $signed({66'h0, floor_sqrt(disc)});
            mb  = -b;
            den = 2 * a;
            div_clamp((mb + rr) * 65536, den, r1, s1);
            div_clamp((mb - rr) * 65536, den, r2, s2);
            if (r1 < 0) begin r.t = r2; r.sat = s2; end
            else if (r2 < 0) begin r.t = r1; r.sat = s1; end
            else begin
                opp = (nv < 0 && vt > 0) || (nv > 0 && vt < 0);
                if (opp ? (r1 <= r2) : (r1 >= r2)) begin r.t = r1; r.sat = s1; end
                else begin r.t = r2; r.sat = s2; end
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        logic [31:0] ext [5] = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h1, 32'hFFFFFFFF};
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3:       return 32'($urandom_range(0, 64)) - 32'd32;
            4:       return ext[$urandom_range(0, 4)];
            default: return 32'($urandom_range(0, 32'h3FFFFF)) - 32'h200000;
        endcase
    endfunction

    function automatic t_query rand_query();
        t_query q;
        int     pick;
        for (int i = 0; i < 12; i++) q.f[i] = rand_word();
        pick = $urandom_range(0, 19);
        if (pick < 3) begin
            for (int i = 0; i < 3; i++) q.f[6+i] = q.f[i];
            if (pick == 0) for (int i = 3; i < 6; i++) q.f[i] = '0;
        end
        return q;
    endfunction

    function automatic t_query mk_query(input logic [31:0] px, input logic [31:0] tx,
                                        input logic [31:0] ty, input logic [31:0] vx,
                                        input logic [31:0] vy);
        t_query q;
        q = '0;
        q.f[0] = px; q.f[6] = tx; q.f[7] = ty; q.f[3] = vx; q.f[4] = vy;
        return q;
    endfunction

    function automatic t_tof mk_tof(input logic [31:0] t, input t_axis ax, input t_path p,
                                    input logic s);
        t_tof r;
        r.t = t; r.ax = ax; r.path = p; r.sat = s;
        return r;
    endfunction

    // one write, then the enable drops again
    task automatic cfg_write(input t_cfg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_DRAG_COEFF: k_reg     = val;
            CFG_TVEL_X:     tv_reg[0] = val;
            CFG_TVEL_Y:     tv_reg[1] = val;
            CFG_TVEL_Z:     tv_reg[2] = val;
            CFG_SMALL_THR:  thr_reg   = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic send_query(input t_query q, input logic he, input t_tof ex);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        cur_q       <= q;
        cur_has_exp <= he;
        cur_exp     <= ex;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic drain();
        i_valid  <= 1'b0;
        i_cfg_we <= 1'b0;
        while (tof_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // expectations are formed at the input transfer
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            tof_q.push_back(cur_has_exp ? cur_exp : predict_tof(cur_q));
    end

    always @(posedge i_clk) begin
        t_tof e;
        if (i_rst_n && o_valid && !i_stall) begin
            n_done++;
            if (tof_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result t=%0d", o_flight_time);
            end else begin
                e = tof_q.pop_front();
                if (o_solve_path < 3) n_path[o_solve_path]++;
                if (o_flight_time !== e.t || o_solve_axis !== e.ax ||
                    o_solve_path !== e.path || o_saturated !== e.sat) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch #%0d: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 n_done, e.t, e.ax, e.path, e.sat,
                                 o_flight_time, o_solve_axis, o_solve_path, o_saturated);
                end
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    always @(posedge i_clk) begin
        if (press_req && !press_done) begin
            i_stall <= 1'b1;
            hold_cnt++;
            if (hold_cnt >= HOLD_CYCLES) press_done = 1;
        end else begin
            i_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle_cnt = 0;
        else idle_cnt++;
        if (idle_cnt >= WDOG_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", idle_cnt);
            $display("drag_trajectory_time_of_flight test failed");
            $finish;
        end
    end

    initial begin
        t_row rows [$];
        t_tof none;
        none = '0;
        // registers at reset: linear solve only
        rows.push_back('{mk_query(0, 0, 0, 0, 0), 1, mk_tof(0, AX_X, PATH_DEGEN, 0)});
        rows.push_back('{mk_query(0, 1, 0, 0, 0), 1, mk_tof(0, AX_X, PATH_DEGEN, 0)});
        rows.push_back('{mk_query(0, 0, 5, 0, 0), 1, mk_tof(0, AX_Y, PATH_DEGEN, 0)});
        rows.push_back('{mk_query(0, 32'h10000, 0, 32'h10000, 0), 1,
                         mk_tof(32'h10000, AX_X, PATH_LIN, 0)});
        rows.push_back('{mk_query(32'h80000000, 32'h7FFFFFFF, 0, 1, 0), 1,
                         mk_tof(32'h7FFFFFFF, AX_X, PATH_LIN, 1)});
        rows.push_back('{mk_query(32'h7FFFFFFF, 32'h80000000, 0, 1, 0), 1,
                         mk_tof(32'h80000000, AX_X, PATH_LIN, 1)});
        rows.push_back('{mk_query(0, 0, 0, 0, 32'h7FFFFFFF), 0, none});
        rows.push_back('{mk_query(0, 0, 0, 32'h80000000, 32'h80000000), 0, none});
        rows.push_back('{mk_query(0, 32'h30000, 32'hFFFD0000, 32'hFFFF0000, 0), 0, none});
        rows.push_back('{mk_query(5, 5, 0, 0, 32'hFFFFFFFF), 0, none});
        rows.push_back('{mk_query(32'h12345, 32'hFFFF0000, 32'h7FFF0000, 32'h80000, 3), 0, none});
        for (int i = 0; i < 8; i++) rows.push_back('{rand_query(), 0, none});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (rows[i]) send_query(rows[i].q, rows[i].has_exp, rows[i].exp);
        drain();

        for (int p = 1; p <= N_PHASES; p++) begin
            case (p)
                1: begin
                    cfg_write(CFG_DRAG_COEFF, 32'h4000);
                    cfg_write(CFG_TVEL_X, 32'hFFF60000);
                    cfg_write(CFG_TVEL_Y, 32'h00090000);
                    cfg_write(CFG_TVEL_Z, 32'hFFFB0000);
                    cfg_write(CFG_SMALL_THR, 32'd1);
                end
                2: begin
                    cfg_write(CFG_DRAG_COEFF, 32'h7FFFFFFF);
                    cfg_write(CFG_TVEL_X, 32'h80000000);
                    cfg_write(CFG_TVEL_Y, 32'h7FFFFFFF);
                    cfg_write(CFG_TVEL_Z, 32'h80000000);
                    cfg_write(CFG_SMALL_THR, 32'hFFFF);
                end
                3: begin
                    cfg_write(CFG_DRAG_COEFF, 32'hFFFF8000);
                    cfg_write(CFG_TVEL_X, 32'd0);
                    cfg_write(CFG_TVEL_Y, 32'd1);
                    cfg_write(CFG_TVEL_Z, 32'hFFFFFFFF);
                    cfg_write(CFG_SMALL_THR, 32'd0);
                end
                default: begin
                    cfg_write(CFG_DRAG_COEFF, ($urandom_range(0, 3) == 0) ? $urandom :
                              32'($urandom_range(0, 32'h40000)) - 32'h20000);
                    cfg_write(CFG_TVEL_X, rand_word());
                    cfg_write(CFG_TVEL_Y, rand_word());
                    cfg_write(CFG_TVEL_Z, rand_word());
                    cfg_write(CFG_SMALL_THR, ($urandom_range(0, 3) == 0) ?
                              32'($urandom_range(0, 16'hFFFF)) : 32'($urandom_range(0, 16)));
                end
            endcase
            calm = (p == 4);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 1 && i == 40) press_req = 1;
                send_query(rand_query(), 1'b0, none);
            end
            drain();
        end

        $display("%0d queries over %0d register settings, one long output hold-off",
                 n_sent, N_PHASES + 1);
        $display("results: %0d quadratic, %0d linear, %0d degenerate, %0d mismatches",
                 n_path[0], n_path[1], n_path[2], n_bad);
        if (n_bad == 0 && tof_q.size() == 0) begin
            $display("drag_trajectory_time_of_flight test passed");
        end else begin
            $display("drag_trajectory_time_of_flight test failed");
        end
        $finish;
    end

endmodule
